>>> hdl/lifo_fifo_priority_trace_checker_core_macros.svh
// Assertion helpers for the trace checker.
`ifndef LIFO_FIFO_PRIORITY_TRACE_CHECKER_CORE_MACROS_SVH
`define LIFO_FIFO_PRIORITY_TRACE_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LFPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define LFPT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define LFPT_ASSERT(lbl, prop, msg)
`define LFPT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> hdl/lfpt_pkg.sv
package lfpt_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [VALUE_BITS-1:0] val_t;

    localparam logic [ADDR_W:0] CAP_WIDE  = (ADDR_W + 1)'(CAPACITY);
    localparam cnt_t            CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] VERDICT_STACK      = 3'd0;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd1;
    localparam logic [2:0] VERDICT_PRIO       = 3'd2;
    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd3;
    localparam logic [2:0] VERDICT_UNSURE     = 3'd4;

    localparam int ALIVE_STACK = 0;
    localparam int ALIVE_FIFO  = 1;
    localparam int ALIVE_PRIO  = 2;

    localparam logic [2:0] ALIVE_ALL    = 3'b111;
    localparam logic [2:0] ONLY_STACK   = 3'b001;
    localparam logic [2:0] ONLY_FIFO    = 3'b010;
    localparam logic [2:0] ONLY_PRIO    = 3'b100;
    localparam logic [2:0] ALIVE_NONE   = 3'b000;

    typedef struct packed {
        logic  valid;
        logic  first;
        addr_t idx;
    } scan_ctrl_t;

    typedef struct packed {
        val_t  best;
        addr_t best_idx;
        val_t  last;
    } scan_result_t;

    function automatic addr_t fifo_wrap(logic [ADDR_W:0] idx);
        logic [ADDR_W:0] adj;
        adj = (idx >= CAP_WIDE) ? idx - CAP_WIDE : idx;
        return adj[ADDR_W-1:0];
    endfunction

    function automatic logic [2:0] verdict_of(logic [2:0] alive);
        logic [2:0] v;
        case (alive)
            ONLY_STACK: v = VERDICT_STACK;
            ONLY_FIFO:  v = VERDICT_QUEUE;
            ONLY_PRIO:  v = VERDICT_PRIO;
            ALIVE_NONE: v = VERDICT_IMPOSSIBLE;
            default:    v = VERDICT_UNSURE;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/lfpt_ram.sv
module lfpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lfpt_max_scan.sv
// Running maximum over the beats read out of the priority store.
// Keeps the first index holding the max, and the last entry seen
// (the tail, used to fill the hole left by the removed max).
module lfpt_max_scan import lfpt_pkg::*; (
    input  logic         aclk,
    input  scan_ctrl_t   ctrl,
    input  val_t         rdata,
    output scan_result_t result
);

    val_t  best_reg;
    addr_t best_idx_reg;
    val_t  last_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.valid) begin
            if (ctrl.first || (rdata > best_reg)) begin
                best_reg     <= rdata;
                best_idx_reg <= ctrl.idx;
            end
            last_reg <= rdata;
        end
    end

    assign result.best     = best_reg;
    assign result.best_idx = best_idx_reg;
    assign result.last     = last_reg;

endmodule

>>> hdl/lifo_fifo_priority_trace_checker_core.sv
// Push, restart and unused opcodes go from the start state to the commit state, where the result loads;
// a pop runs the scan state between them, where the max search reads the priority memory one entry per
// cycle while that discipline holds and the store is nonempty.
// Throughput: one item at a time; the next beat is taken the cycle after the result loads, and
// the commit waits while the previous result beat is still unaccepted.
// Reset (aresetn low, synchronous) clears counts, fifo head, flags and handshake; no RAM clear.
`include "lifo_fifo_priority_trace_checker_core_macros.svh"

module lifo_fifo_priority_trace_checker_core import lfpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[15:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // verdict[2:0], stack[3], fifo[4], prio[5], overflow[6], 0
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    val_t       val_reg, val_next;
    cnt_t       lifo_count_reg, lifo_count_next;
    addr_t      fifo_head_reg, fifo_head_next;
    cnt_t       fifo_count_reg, fifo_count_next;
    cnt_t       prio_count_reg, prio_count_next;
    logic [2:0] alive_reg, alive_next;
    logic       lifo_ok_reg, lifo_ok_next;
    logic       fifo_ok_reg, fifo_ok_next;
    addr_t      scan_idx_reg, scan_idx_next;
    logic       first_reg, first_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    logic  lifo_we, lifo_re, fifo_we, fifo_re, prio_we, prio_re;
    addr_t lifo_waddr, lifo_raddr, fifo_waddr, fifo_raddr, prio_waddr, prio_raddr;
    val_t  lifo_rdata, fifo_rdata, prio_rdata, prio_wdata;

    scan_ctrl_t   scan_ctrl;
    scan_result_t scan_res;

    logic prio_active;
    logic ovf;

    lfpt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_lifo_ram (
        .aclk  (aclk),
        .we    (lifo_we),
        .waddr (lifo_waddr),
        .wdata (val_reg),
        .re    (lifo_re),
        .raddr (lifo_raddr),
        .rdata (lifo_rdata)
    );

    lfpt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (val_reg),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    lfpt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_prio_ram (
        .aclk  (aclk),
        .we    (prio_we),
        .waddr (prio_waddr),
        .wdata (prio_wdata),
        .re    (prio_re),
        .raddr (prio_raddr),
        .rdata (prio_rdata)
    );

    lfpt_max_scan u_max_scan (
        .aclk   (aclk),
        .ctrl   (scan_ctrl),
        .rdata  (prio_rdata),
        .result (scan_res)
    );

    assign prio_active = alive_reg[ALIVE_PRIO] && (prio_count_reg != '0);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        lifo_count_next = lifo_count_reg;
        fifo_head_next  = fifo_head_reg;
        fifo_count_next = fifo_count_reg;
        prio_count_next = prio_count_reg;
        alive_next      = alive_reg;
        lifo_ok_next    = lifo_ok_reg;
        fifo_ok_next    = fifo_ok_reg;
        scan_idx_next   = scan_idx_reg;
        first_next      = first_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        lifo_we    = 1'b0;
        lifo_re    = 1'b0;
        lifo_waddr = lifo_count_reg[ADDR_W-1:0];
        lifo_raddr = addr_t'(lifo_count_reg - cnt_t'(1));
        fifo_we    = 1'b0;
        fifo_re    = 1'b0;
        fifo_waddr = fifo_wrap({1'b0, fifo_head_reg} + (ADDR_W + 1)'(fifo_count_reg));
        fifo_raddr = fifo_head_reg;
        prio_we    = 1'b0;
        prio_re    = 1'b0;
        prio_waddr = prio_count_reg[ADDR_W-1:0];
        prio_wdata = val_reg;
        prio_raddr = '0;

        scan_ctrl.valid = 1'b0;
        scan_ctrl.first = (scan_idx_reg == '0);
        scan_ctrl.idx   = scan_idx_reg;
        ovf             = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    val_next   = s_tdata[VALUE_BITS-1:0];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (op_reg == OP_POP) begin
                    lifo_re       = alive_reg[ALIVE_STACK] && (lifo_count_reg != '0);
                    fifo_re       = alive_reg[ALIVE_FIFO] && (fifo_count_reg != '0);
                    prio_re       = prio_active;
                    scan_idx_next = '0;
                    first_next    = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (first_reg) begin
                    lifo_ok_next = (lifo_count_reg != '0) && (lifo_rdata == val_reg);
                    fifo_ok_next = (fifo_count_reg != '0) && (fifo_rdata == val_reg);
                    first_next   = 1'b0;
                end
                scan_ctrl.valid = prio_active;
                if (prio_active && ((cnt_t'(scan_idx_reg) + cnt_t'(1)) < prio_count_reg)) begin
                    prio_re       = 1'b1;
                    prio_raddr    = scan_idx_reg + addr_t'(1);
                    scan_idx_next = scan_idx_reg + addr_t'(1);
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    case (op_reg)
                        OP_PUSH: begin
                            if (alive_reg[ALIVE_STACK]) begin
                                if (lifo_count_reg < CAP_COUNT) begin
                                    lifo_we         = 1'b1;
                                    lifo_count_next = lifo_count_reg + cnt_t'(1);
                                end else begin
                                    ovf = 1'b1;
                                end
                            end
                            if (alive_reg[ALIVE_FIFO]) begin
                                if (fifo_count_reg < CAP_COUNT) begin
                                    fifo_we         = 1'b1;
                                    fifo_count_next = fifo_count_reg + cnt_t'(1);
                                end else begin
                                    ovf = 1'b1;
                                end
                            end
                            if (alive_reg[ALIVE_PRIO]) begin
                                if (prio_count_reg < CAP_COUNT) begin
                                    prio_we         = 1'b1;
                                    prio_count_next = prio_count_reg + cnt_t'(1);
                                end else begin
                                    ovf = 1'b1;
                                end
                            end
                        end
                        OP_POP: begin
                            if (alive_reg[ALIVE_STACK]) begin
                                if (lifo_ok_reg) begin
                                    lifo_count_next = lifo_count_reg - cnt_t'(1);
                                end else begin
                                    alive_next[ALIVE_STACK] = 1'b0;
                                end
                            end
                            if (alive_reg[ALIVE_FIFO]) begin
                                if (fifo_ok_reg) begin
                                    fifo_head_next  = fifo_wrap({1'b0, fifo_head_reg} +
                                                                (ADDR_W + 1)'(1));
                                    fifo_count_next = fifo_count_reg - cnt_t'(1);
                                end else begin
                                    alive_next[ALIVE_FIFO] = 1'b0;
                                end
                            end
                            if (alive_reg[ALIVE_PRIO]) begin
                                if (prio_active && (scan_res.best == val_reg)) begin
                                    // move the tail entry into the slot of the removed max
                                    prio_we         = 1'b1;
                                    prio_waddr      = scan_res.best_idx;
                                    prio_wdata      = scan_res.last;
                                    prio_count_next = prio_count_reg - cnt_t'(1);
                                end else begin
                                    alive_next[ALIVE_PRIO] = 1'b0;
                                end
                            end
                        end
                        OP_RESTART: begin
                            lifo_count_next = '0;
                            fifo_head_next  = '0;
                            fifo_count_next = '0;
                            prio_count_next = '0;
                            alive_next      = ALIVE_ALL;
                        end
                        default: begin
                        end
                    endcase
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, ovf, alive_next[ALIVE_PRIO], alive_next[ALIVE_FIFO],
                                     alive_next[ALIVE_STACK], verdict_of(alive_next)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lifo_count_reg <= '0;
            fifo_head_reg  <= '0;
            fifo_count_reg <= '0;
            prio_count_reg <= '0;
            alive_reg      <= ALIVE_ALL;
            first_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            lifo_count_reg <= lifo_count_next;
            fifo_head_reg  <= fifo_head_next;
            fifo_count_reg <= fifo_count_next;
            prio_count_reg <= prio_count_next;
            alive_reg      <= alive_next;
            first_reg      <= first_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        lifo_ok_reg  <= lifo_ok_next;
        fifo_ok_reg  <= fifo_ok_next;
        scan_idx_reg <= scan_idx_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LFPT_ASSERT(a_counts_in_range, (lifo_count_reg <= CAP_COUNT) && (fifo_count_reg <= CAP_COUNT) && (prio_count_reg <= CAP_COUNT), "store count above capacity")
    `LFPT_ASSERT(a_fifo_head_in_range, fifo_head_reg < addr_t'(CAPACITY - 1) || fifo_head_reg == addr_t'(CAPACITY - 1), "fifo head past capacity")
    `LFPT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "beat accepted while busy")
    `LFPT_ASSERT(a_result_from_commit, $rose(m_tvalid) |-> $past(state_reg == ST_FIN), "result without commit")
    `LFPT_ASSERT_NEXT(a_one_write_per_store, lifo_we || fifo_we || prio_we, state_reg == ST_IDLE, "store write outside commit")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lfpt_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         RAND_ITEMS  = 370;
    localparam int         LONG_HOLD   = 400;
    localparam int         SCAN_DEPTH  = 150;

    typedef struct packed {
        logic       ovf;
        logic       prio_ok;
        logic       fifo_ok;
        logic       stack_ok;
        logic [2:0] verdict;
    } status_t;

    typedef enum int { GEN_STACK, GEN_FIFO, GEN_PRIO } trace_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // value[15:0]
    logic [1:0]  s_tuser  = '0;    // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // verdict[2:0], stack[3], fifo[4], prio[5], overflow[6], 0

    lifo_fifo_priority_trace_checker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow of the three stores
    val_t       lifo_mem [0:CAPACITY-1];
    val_t       fifo_mem [0:CAPACITY-1];
    val_t       prio_mem [0:CAPACITY-1];
    int         lifo_cnt   = 0;
    int         fifo_head  = 0;
    int         fifo_cnt   = 0;
    int         prio_cnt   = 0;
    logic [2:0] alive      = ALIVE_ALL;

    status_t    status_q [$];
    int         err_cnt     = 0;
    int         result_cnt  = 0;
    int         cycle_cnt   = 0;
    int         burst_left  = 0;
    int         random_sent = 0;
    bit         rx_hold_req = 1'b0;

    function automatic status_t trace_step(logic [1:0] op, val_t val);
        status_t st;
        logic    drop;
        int      best_idx;
        drop = 1'b0;
        case (op)
            OP_PUSH: begin
                if (alive[ALIVE_STACK]) begin
                    if (lifo_cnt < CAPACITY) begin
                        lifo_mem[lifo_cnt] = val;
                        lifo_cnt++;
                    end else begin
                        drop = 1'b1;
                    end
                end
                if (alive[ALIVE_FIFO]) begin
                    if (fifo_cnt < CAPACITY) begin
                        fifo_mem[(fifo_head + fifo_cnt) % CAPACITY] = val;
                        fifo_cnt++;
                    end else begin
                        drop = 1'b1;
                    end
                end
                if (alive[ALIVE_PRIO]) begin
                    if (prio_cnt < CAPACITY) begin
                        prio_mem[prio_cnt] = val;
                        prio_cnt++;
                    end else begin
                        drop = 1'b1;
                    end
                end
            end
            OP_POP: begin
                if (alive[ALIVE_STACK]) begin
                    if (lifo_cnt != 0 && lifo_mem[lifo_cnt-1] == val) begin
                        lifo_cnt--;
                    end else begin
                        alive[ALIVE_STACK] = 1'b0;
                    end
                end
                if (alive[ALIVE_FIFO]) begin
                    if (fifo_cnt != 0 && fifo_mem[fifo_head] == val) begin
                        fifo_head = (fifo_head + 1) % CAPACITY;
                        fifo_cnt--;
                    end else begin
                        alive[ALIVE_FIFO] = 1'b0;
                    end
                end
                if (alive[ALIVE_PRIO]) begin
                    best_idx = -1;
                    for (int i = 0; i < prio_cnt; i++) begin
                        if (best_idx < 0 || prio_mem[i] > prio_mem[best_idx]) best_idx = i;
                    end
                    // one copy of a repeated max goes; the last entry fills the hole
                    if (best_idx >= 0 && prio_mem[best_idx] == val) begin
                        prio_cnt--;
                        prio_mem[best_idx] = prio_mem[prio_cnt];
                    end else begin
                        alive[ALIVE_PRIO] = 1'b0;
                    end
                end
            end
            OP_RESTART: begin
                lifo_cnt  = 0;
                fifo_head = 0;
                fifo_cnt  = 0;
                prio_cnt  = 0;
                alive     = ALIVE_ALL;
            end
            default: ;
        endcase
        case (alive)
            ONLY_STACK: st.verdict = VERDICT_STACK;
            ONLY_FIFO:  st.verdict = VERDICT_QUEUE;
            ONLY_PRIO:  st.verdict = VERDICT_PRIO;
            ALIVE_NONE: st.verdict = VERDICT_IMPOSSIBLE;
            default:    st.verdict = VERDICT_UNSURE;
        endcase
        st.stack_ok = alive[ALIVE_STACK];
        st.fifo_ok  = alive[ALIVE_FIFO];
        st.prio_ok  = alive[ALIVE_PRIO];
        st.ovf      = drop;
        return st;
    endfunction

    function automatic int max_index(const ref val_t q[$]);
        int idx;
        idx = 0;
        for (int i = 1; i < q.size(); i++) begin
            if (q[i] > q[idx]) idx = i;
        end
        return idx;
    endfunction

    task automatic report_mismatch(string what, int got_val, int want_val);
        if (err_cnt < 40) begin
            $display("[%0t] mismatch on result %0d, %s: got %0d, want %0d",
                     $realtime, result_cnt, what, got_val, want_val);
        end
        err_cnt++;
    endtask

    // sender works in bursts; the beat counts once tvalid and tready meet at an edge
    task automatic send_beat(logic [1:0] op, val_t val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_q.push_back(trace_step(op, val));
        burst_left--;
    endtask

    task automatic wait_results_done();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (status_q.size() != 0);
    endtask

    // receiver: random stall modes, plus one long hold on request
    initial begin : rx_pattern
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    status_t got_st, want_st;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_st = status_t'(m_tdata[6:0]);
            if (status_q.size() == 0) begin
                report_mismatch("beat with nothing expected", int'(m_tdata), 0);
            end else begin
                want_st = status_q.pop_front();
                if (got_st.verdict != want_st.verdict)
                    report_mismatch("verdict", int'(got_st.verdict), int'(want_st.verdict));
                if (got_st.stack_ok != want_st.stack_ok)
                    report_mismatch("stack_consistent", int'(got_st.stack_ok),
                                    int'(want_st.stack_ok));
                if (got_st.fifo_ok != want_st.fifo_ok)
                    report_mismatch("fifo_consistent", int'(got_st.fifo_ok),
                                    int'(want_st.fifo_ok));
                if (got_st.prio_ok != want_st.prio_ok)
                    report_mismatch("prio_consistent", int'(got_st.prio_ok),
                                    int'(want_st.prio_ok));
                if (got_st.ovf != want_st.ovf)
                    report_mismatch("overflow", int'(got_st.ovf), int'(want_st.ovf));
            end
            result_cnt++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        // field extremes; fifo dies, then an empty pop kills the rest
        send_beat(OP_PUSH, 16'h0000);
        send_beat(OP_PUSH, 16'hFFFF);
        send_beat(OP_POP, 16'hFFFF);
        send_beat(OP_POP, 16'h0000);
        send_beat(OP_POP, 16'h0000);
        send_beat(OP_PUSH, 16'hA5A5);    // nothing consistent, so no overflow
        send_beat(OP_UNUSED, 16'h5A5A);
        send_beat(OP_RESTART, 16'h0000);
        send_beat(OP_POP, 16'h1234);     // pop on empty stores
        // stack only
        send_beat(OP_RESTART, 16'hFFFF);
        send_beat(OP_PUSH, 16'd2);
        send_beat(OP_PUSH, 16'd1);
        send_beat(OP_POP, 16'd1);
        // queue only
        send_beat(OP_RESTART, 16'h0000);
        send_beat(OP_PUSH, 16'd1);
        send_beat(OP_PUSH, 16'd2);
        send_beat(OP_POP, 16'd1);
        // priority only
        send_beat(OP_RESTART, 16'h0000);
        send_beat(OP_PUSH, 16'd1);
        send_beat(OP_PUSH, 16'd3);
        send_beat(OP_PUSH, 16'd2);
        send_beat(OP_POP, 16'd3);
        // repeated maximum
        send_beat(OP_RESTART, 16'h0000);
        send_beat(OP_PUSH, 16'd5);
        send_beat(OP_PUSH, 16'd5);
        send_beat(OP_PUSH, 16'd3);
        send_beat(OP_POP, 16'd5);
        send_beat(OP_POP, 16'd5);
        send_beat(OP_POP, 16'd3);
        send_beat(OP_UNUSED, 16'hFFFF);
        wait_results_done();
    endtask

    // deep priority store: the max search covers many entries
    task automatic test_full_prio_scan();
        val_t pushed [$];
        val_t v;
        int   idx;
        send_beat(OP_RESTART, 16'h0000);
        for (int i = 0; i < SCAN_DEPTH; i++) begin
            v = val_t'($urandom_range(0, 65535));
            pushed.push_back(v);
            send_beat(OP_PUSH, v);
        end
        for (int i = 0; i < 3; i++) begin
            idx = max_index(pushed);
            v   = pushed[idx];
            pushed.delete(idx);
            send_beat(OP_POP, v);
        end
        for (int i = 0; i < 4; i++) send_beat(OP_PUSH, val_t'($urandom_range(0, 65535)));
        wait_results_done();
    endtask

    // mostly well-formed traces of one discipline, with some noise and broken pops
    task automatic test_random_traces();
        val_t        shadow [$];
        val_t        v;
        trace_kind_t kind;
        int          seq_len;
        int          r;
        int          idx;
        bit          wide;
        logic [1:0]  op;
        rx_hold_req = 1'b1;
        while (random_sent < RAND_ITEMS) begin
            shadow.delete();
            if ($urandom_range(0, 99) < 85) begin
                send_beat(OP_RESTART, val_t'($urandom_range(0, 65535)));
                random_sent++;
            end
            kind    = trace_kind_t'($urandom_range(0, 2));
            wide    = 1'($urandom_range(0, 1));
            seq_len = $urandom_range(3, 24);
            for (int n = 0; n < seq_len; n++) begin
                r = $urandom_range(0, 99);
                v = wide ? val_t'($urandom_range(0, 65535)) : val_t'($urandom_range(0, 7));
                if (r < 8) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_UNUSED;
                        1:       op = OP_POP;
                        default: op = OP_RESTART;
                    endcase
                    if (op == OP_RESTART) shadow.delete();
                end else if (shadow.size() == 0 || r < 55) begin
                    op = OP_PUSH;
                    shadow.push_back(v);
                end else begin
                    op = OP_POP;
                    case (kind)
                        GEN_STACK: v = shadow.pop_back();
                        GEN_FIFO:  v = shadow.pop_front();
                        default: begin
                            idx = max_index(shadow);
                            v   = shadow[idx];
                            shadow.delete(idx);
                        end
                    endcase
                end
                send_beat(op, v);
                if (op != OP_UNUSED) random_sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_results_done();
        end
        wait_results_done();
    endtask

    initial begin : main_seq
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_prio_scan();
        test_random_traces();
        repeat (50) @(posedge aclk);
        if (status_q.size() != 0) report_mismatch("results never delivered", status_q.size(), 0);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lfpt_pkg.sv
hdl/lfpt_ram.sv
hdl/lfpt_max_scan.sv
hdl/lifo_fifo_priority_trace_checker_core.sv
verif/tb_top.sv
